// ===== rtl/core/flna_pkg.sv =====
// flna_pkg: shared types and codes for the free-list node allocator
// no dependencies; imported by free_list_node_allocator
`default_nettype none

package flna_pkg;

    localparam int FUNC_W   = 2;
    localparam int NODE_W   = 11;
    localparam int GNODE_W  = 10;
    localparam int ERR_W    = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE   = 2'd0,
        ERR_STATE  = 2'd1,
        ERR_NODE   = 2'd2,
        ERR_DOUBLE = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/flna_ram.sv =====
// flna_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for the link memory and the in-use marks
`default_nettype none

module flna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/free_list_node_allocator.sv =====
// free_list_node_allocator: lifo free list of node slots kept in a link ram
// depends on flna_pkg and flna_ram
//
// channel   dir  tdata (lsb up)                          tuser
// s_        in   node_index[10:0], zero pad to 16        func[1:0]
// m_        out  granted_node[9:0], error_code[1:0], pad granted
//
// allocate and release read the link and mark rams on acceptance, then
// compute and write back in the exec state. clear sweeps the rams one
// slot a cycle. rams need no pass after reset: nothing uses what they
// read before the first clear. the result sits in an output register;
// a request finishing while that register is still full waits for it.
`default_nettype none

module free_list_node_allocator
    import flna_pkg::*;
#(
    parameter int POOL_NODES = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // node_index[10:0], zeros
    input  wire logic [FUNC_W-1:0]   s_tuser,  // func[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,  // granted_node[9:0], error_code[11:10], zeros
    output logic      [0:0]          m_tuser   // granted
);

    localparam int IDX_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(POOL_NODES);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(POOL_NODES - 1);

    state_t              state_reg, state_next;
    func_t               func_reg, func_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]    sweep_reg, sweep_next;
    err_t                error_reg, error_next;
    logic                ready_reg, ready_next;

    logic                out_valid_reg, out_valid_next;
    logic [GNODE_W-1:0]  gnode_reg, gnode_next;
    logic                granted_reg, granted_next;
    err_t                err_out_reg, err_out_next;

    logic                link_wr_en, mark_wr_en, rd_en;
    logic [IDX_W-1:0]    link_wr_addr, mark_wr_addr, link_rd_addr, mark_rd_addr;
    logic [LINK_W-1:0]   link_wr_data, link_rd_data;
    logic [0:0]          mark_wr_data, mark_rd_data;

    logic                out_free, accept, node_ok;
    logic [NODE_W-1:0]   s_node;
    func_t               s_func;

    assign s_node   = s_tdata[NODE_W-1:0];
    assign s_func   = func_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign node_ok  = (32'(node_reg) < POOL_NODES);

    assign rd_en        = accept;
    assign link_rd_addr = IDX_W'(head_reg);
    assign mark_rd_addr = IDX_W'(s_node);

    flna_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    flna_ram #(.WIDTH(1), .DEPTH(POOL_NODES)) u_mark_ram (
        .aclk    (aclk),
        .wr_en   (mark_wr_en),
        .wr_addr (mark_wr_addr),
        .wr_data (mark_wr_data),
        .rd_en   (rd_en),
        .rd_addr (mark_rd_addr),
        .rd_data (mark_rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        node_next      = node_reg;
        head_next      = head_reg;
        sweep_next     = sweep_reg;
        error_next     = error_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && !m_tready;
        gnode_next     = gnode_reg;
        granted_next   = granted_reg;
        err_out_next   = err_out_reg;
        link_wr_en     = 1'b0;
        mark_wr_en     = 1'b0;
        link_wr_addr   = IDX_W'(head_reg);
        mark_wr_addr   = IDX_W'(head_reg);
        link_wr_data   = NONE_MARK;
        mark_wr_data   = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next  = s_func;
                    node_next  = s_node;
                    sweep_next = '0;
                    state_next = (s_func == FUNC_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    gnode_next     = '0;
                    granted_next   = 1'b0;
                    err_out_next   = error_reg;
                    state_next     = ST_IDLE;
                    if (func_reg == FUNC_NOP) begin
                        err_out_next = error_reg;
                    end else if (!ready_reg) begin
                        // use before the first clear
                        if (error_reg == ERR_NONE) begin
                            error_next   = ERR_STATE;
                            err_out_next = ERR_STATE;
                        end
                    end else if (error_reg != ERR_NONE) begin
                        err_out_next = error_reg;
                    end else if (func_reg == FUNC_ALLOC) begin
                        if (head_reg != NONE_MARK) begin
                            // pop: unlink the head slot and mark it taken
                            link_wr_en   = 1'b1;
                            mark_wr_en   = 1'b1;
                            link_wr_data = NONE_MARK;
                            mark_wr_data = 1'b1;
                            head_next    = link_rd_data;
                            gnode_next   = GNODE_W'(head_reg);
                            granted_next = 1'b1;
                        end
                    end else if (!node_ok) begin
                        error_next   = ERR_NODE;
                        err_out_next = ERR_NODE;
                    end else if (mark_rd_data == 1'b0) begin
                        error_next   = ERR_DOUBLE;
                        err_out_next = ERR_DOUBLE;
                    end else begin
                        // push the released slot on top of the list
                        link_wr_en   = 1'b1;
                        mark_wr_en   = 1'b1;
                        link_wr_addr = IDX_W'(node_reg);
                        mark_wr_addr = IDX_W'(node_reg);
                        link_wr_data = head_reg;
                        mark_wr_data = 1'b0;
                        head_next    = LINK_W'(node_reg);
                    end
                end
            end
            ST_CLEAR: begin
                link_wr_en   = 1'b1;
                mark_wr_en   = 1'b1;
                link_wr_addr = sweep_reg;
                mark_wr_addr = sweep_reg;
                link_wr_data = LINK_W'(sweep_reg) + LINK_W'(1);
                mark_wr_data = 1'b0;
                if (sweep_reg != LAST_IDX) begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end else if (out_free) begin
                    // last slot rewritten harmlessly while waiting on the output
                    head_next      = '0;
                    error_next     = ERR_NONE;
                    ready_next     = 1'b1;
                    out_valid_next = 1'b1;
                    gnode_next     = '0;
                    granted_next   = 1'b0;
                    err_out_next   = ERR_NONE;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= NONE_MARK;
            error_reg     <= ERR_NONE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            error_reg     <= error_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
        func_reg    <= func_next;
        node_reg    <= node_next;
        sweep_reg   <= sweep_next;
        gnode_reg   <= gnode_next;
        granted_reg <= granted_next;
        err_out_reg <= err_out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - GNODE_W - ERR_W){1'b0}}, err_out_reg, gnode_reg};
    assign m_tuser  = granted_reg;

endmodule

`default_nettype wire
